// ----- rtl/core/nfb_pkg.sv -----
// Package: frame geometry, command codes, payload and control types of the draw engine.
package nfb_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int BLOCK_SIZE    = 16;
    localparam int STORE_BYTES   = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2;
    localparam int PIX_W         = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    // Walk coordinates: start (9 or 8 bits) plus a count of up to 255 fits in 10 bits.
    localparam int COORD_W       = 10;

    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_HSPAN = 3'd2;
    localparam logic [2:0] ACT_VSPAN = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [8:0] x;
        logic [7:0] y;
        logic [8:0] span_end;
        logic [7:0] thickness;
        logic [3:0] color;
    } cmd_t;

    typedef struct packed {
        logic [3:0] pixel_color;
        logic       clipped;
    } result_t;

    typedef struct packed {
        logic              on_screen;
        logic              odd;
        logic [ADDR_W-1:0] byte_addr;
    } pix_loc_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIX,
        ST_RMW,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/core/nfb_pix_unit.sv -----
// Address unit: maps a pixel coordinate to its byte, nibble and on-screen flag.
module nfb_pix_unit (
    input  logic [nfb_pkg::COORD_W-1:0] col,
    input  logic [nfb_pkg::COORD_W-1:0] row,
    output nfb_pkg::pix_loc_t           loc
);

    logic [nfb_pkg::PIX_W-1:0] lin;

    // Row times a constant width reduces to shifts and adds in synthesis.
    assign lin = nfb_pkg::PIX_W'(row) * nfb_pkg::PIX_W'(nfb_pkg::SCREEN_WIDTH)
               + nfb_pkg::PIX_W'(col);

    assign loc.on_screen = (col < nfb_pkg::COORD_W'(nfb_pkg::SCREEN_WIDTH))
                        && (row < nfb_pkg::COORD_W'(nfb_pkg::SCREEN_HEIGHT));
    assign loc.odd       = lin[0];
    assign loc.byte_addr = nfb_pkg::ADDR_W'(lin >> 1);

endmodule

// ----- rtl/core/nibble_framebuffer_draw_engine.sv -----
// Top level: command sequencer, shared address unit and the packed 4-bit frame store.
//
//  Channel  | Ports               | Handshake
//  ---------+---------------------+----------------------------------------
//  command  | start, busy, cmd    | item taken at an edge with start & !busy
//  result   | done, result        | one-cycle strobe, always taken
//
// Every command walks a rectangle of pixels through one address unit. A pixel
// on the screen passes ST_PIX (byte read), then ST_RMW (merged write or nibble
// pick); a pixel off the screen passes ST_PIX alone. Every command ends with the
// ST_DONE result state; an empty span or unused code goes there from ST_IDLE.
// Reset clears the sequencer only; frame contents are undefined until written.
// The result strobe cannot be stalled, and busy stays high until it has shown.
module nibble_framebuffer_draw_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  nfb_pkg::cmd_t    cmd,
    output logic             done,
    output nfb_pkg::result_t result
);

    nfb_pkg::state_t state_reg, state_next;

    logic [2:0]                  action_reg, action_next;
    logic [3:0]                  color_reg, color_next;
    logic [nfb_pkg::COORD_W-1:0] c0_reg, c0_next;
    logic [nfb_pkg::COORD_W-1:0] col_reg, col_next;
    logic [nfb_pkg::COORD_W-1:0] row_reg, row_next;
    logic [nfb_pkg::COORD_W-1:0] col_end_reg, col_end_next;
    logic [nfb_pkg::COORD_W-1:0] row_end_reg, row_end_next;
    logic                        clip_reg, clip_next;
    logic [3:0]                  pix_reg, pix_next;
    logic [nfb_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic                        odd_reg, odd_next;
    logic [7:0]                  rdata_reg;

    logic [nfb_pkg::COORD_W-1:0] set_col_end, set_row_end;
    logic [3:0]                  set_color;
    logic                        rd_en, mem_we;
    logic [7:0]                  wdata;
    logic                        last_col, last_row;
    nfb_pkg::pix_loc_t           loc;

    logic [7:0] mem [nfb_pkg::STORE_BYTES];

    nfb_pix_unit u_pix (
        .col (col_reg),
        .row (row_reg),
        .loc (loc)
    );

    assign busy   = (state_reg != nfb_pkg::ST_IDLE);
    assign done   = (state_reg == nfb_pkg::ST_DONE);
    assign result = '{pixel_color: pix_reg, clipped: clip_reg};

    assign wdata    = odd_reg ? {rdata_reg[7:4], color_reg} : {color_reg, rdata_reg[3:0]};
    assign last_col = ((col_reg + nfb_pkg::COORD_W'(1)) == col_end_reg);
    assign last_row = ((row_reg + nfb_pkg::COORD_W'(1)) == row_end_reg);

    // Every command becomes a rectangle starting at (x, y) with exclusive ends.
    always_comb
    begin
        set_color = cmd.color;
        unique case (cmd.action)
            nfb_pkg::ACT_WRITE, nfb_pkg::ACT_READ:
            begin
                set_col_end = nfb_pkg::COORD_W'(cmd.x) + nfb_pkg::COORD_W'(1);
                set_row_end = nfb_pkg::COORD_W'(cmd.y) + nfb_pkg::COORD_W'(1);
            end
            nfb_pkg::ACT_HSPAN:
            begin
                set_col_end = nfb_pkg::COORD_W'(cmd.span_end);
                set_row_end = nfb_pkg::COORD_W'(cmd.y) + nfb_pkg::COORD_W'(cmd.thickness);
            end
            nfb_pkg::ACT_VSPAN:
            begin
                set_col_end = nfb_pkg::COORD_W'(cmd.x) + nfb_pkg::COORD_W'(cmd.thickness);
                set_row_end = nfb_pkg::COORD_W'(cmd.span_end);
            end
            nfb_pkg::ACT_CLEAR:
            begin
                set_col_end = nfb_pkg::COORD_W'(cmd.x) + nfb_pkg::COORD_W'(nfb_pkg::BLOCK_SIZE);
                set_row_end = nfb_pkg::COORD_W'(cmd.y) + nfb_pkg::COORD_W'(nfb_pkg::BLOCK_SIZE);
                set_color   = 4'd0;
            end
            default:
            begin
                // Unused codes get an empty rectangle.
                set_col_end = nfb_pkg::COORD_W'(cmd.x);
                set_row_end = nfb_pkg::COORD_W'(cmd.y);
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        action_next  = action_reg;
        color_next   = color_reg;
        c0_next      = c0_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        col_end_next = col_end_reg;
        row_end_next = row_end_reg;
        clip_next    = clip_reg;
        pix_next     = pix_reg;
        addr_next    = addr_reg;
        odd_next     = odd_reg;
        rd_en        = 1'b0;
        mem_we       = 1'b0;

        unique case (state_reg)
            nfb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    action_next  = cmd.action;
                    color_next   = set_color;
                    c0_next      = nfb_pkg::COORD_W'(cmd.x);
                    col_next     = nfb_pkg::COORD_W'(cmd.x);
                    row_next     = nfb_pkg::COORD_W'(cmd.y);
                    col_end_next = set_col_end;
                    row_end_next = set_row_end;
                    clip_next    = 1'b0;
                    pix_next     = 4'd0;
                    if ((set_col_end <= nfb_pkg::COORD_W'(cmd.x)) ||
                        (set_row_end <= nfb_pkg::COORD_W'(cmd.y)))
                        state_next = nfb_pkg::ST_DONE;
                    else
                        state_next = nfb_pkg::ST_PIX;
                end
            end
            nfb_pkg::ST_PIX:
            begin
                if (loc.on_screen)
                begin
                    rd_en      = 1'b1;
                    addr_next  = loc.byte_addr;
                    odd_next   = loc.odd;
                    state_next = nfb_pkg::ST_RMW;
                end
                else
                begin
                    clip_next = 1'b1;
                    if (action_reg == nfb_pkg::ACT_READ || (last_col && last_row))
                        state_next = nfb_pkg::ST_DONE;
                    else if (last_col)
                    begin
                        col_next = c0_reg;
                        row_next = row_reg + nfb_pkg::COORD_W'(1);
                    end
                    else
                        col_next = col_reg + nfb_pkg::COORD_W'(1);
                end
            end
            nfb_pkg::ST_RMW:
            begin
                if (action_reg == nfb_pkg::ACT_READ)
                begin
                    pix_next   = odd_reg ? rdata_reg[3:0] : rdata_reg[7:4];
                    state_next = nfb_pkg::ST_DONE;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (last_col && last_row)
                        state_next = nfb_pkg::ST_DONE;
                    else
                    begin
                        state_next = nfb_pkg::ST_PIX;
                        if (last_col)
                        begin
                            col_next = c0_reg;
                            row_next = row_reg + nfb_pkg::COORD_W'(1);
                        end
                        else
                            col_next = col_reg + nfb_pkg::COORD_W'(1);
                    end
                end
            end
            nfb_pkg::ST_DONE:
            begin
                state_next = nfb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfb_pkg::ST_IDLE;
            clip_reg  <= 1'b0;
            pix_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            clip_reg  <= clip_next;
            pix_reg   <= pix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        color_reg   <= color_next;
        c0_reg      <= c0_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        col_end_reg <= col_end_next;
        row_end_reg <= row_end_next;
        addr_reg    <= addr_next;
        odd_reg     <= odd_next;
    end

    // Frame store: one read port and one write port, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= wdata;
        if (rd_en)
            rdata_reg <= mem[loc.byte_addr];
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after the result strobe");

    a_color_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.pixel_color != 4'd0)) |-> (action_reg == nfb_pkg::ACT_READ))
        else $error("nonzero pixel color on a command that is not a read");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((32'(addr_reg) < nfb_pkg::STORE_BYTES) && (action_reg != nfb_pkg::ACT_READ)))
        else $error("frame store write out of range or during a read");

endmodule
